// ===== sv/gpr_pkg.sv =====
// Shared types, register codes and bank helper functions for the GPIO port registers.
// Depends on nothing; every other file uses it by scoped names.
package gpr_pkg;

  localparam int PINS_PER_BANK = 16;
  localparam int NUM_PINS      = 32;
  localparam int REG_W         = 16;
  localparam int MASK_W        = (PINS_PER_BANK < REG_W) ? PINS_PER_BANK : REG_W;

  localparam logic [REG_W-1:0] REG_MASK  = REG_W'((33'd1 << MASK_W) - 33'd1);
  localparam logic [7:0]       IRQ_MASK  = 8'hFF;
  localparam logic [14:0]      FSEL_MASK = 15'h7FFF;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } gpr_op_e;

  typedef enum logic [3:0] {
    REG_DIR0    = 4'd0,
    REG_DIR1    = 4'd1,
    REG_INV0    = 4'd2,
    REG_INV1    = 4'd3,
    REG_SET0    = 4'd4,
    REG_SET1    = 4'd5,
    REG_CLR0    = 4'd6,
    REG_CLR1    = 4'd7,
    REG_IRQ     = 4'd8,
    REG_FSEL    = 4'd9,
    REG_BITRATE = 4'd10
  } gpr_reg_e;

  typedef struct packed {
    gpr_op_e          op;
    logic [3:0]       idx;
    logic [REG_W-1:0] data;
  } gpr_access_t;

  // Place a bank-register value at its bank's pin positions; bits past pin 31 drop.
  function automatic logic [NUM_PINS-1:0] bank_up(logic [REG_W-1:0] v, logic bank);
    logic [NUM_PINS-1:0] wide;
    wide = {{(NUM_PINS-REG_W){1'b0}}, v};
    if (!bank) begin
      return wide;
    end else if (PINS_PER_BANK >= NUM_PINS) begin
      return '0;
    end else begin
      return wide << PINS_PER_BANK;
    end
  endfunction

  // Pull one bank's pins down to register position, masked to the register width.
  function automatic logic [REG_W-1:0] bank_down(logic [NUM_PINS-1:0] v, logic bank);
    logic [NUM_PINS-1:0] sh;
    if (!bank) begin
      sh = v;
    end else if (PINS_PER_BANK >= NUM_PINS) begin
      sh = '0;
    end else begin
      sh = v >> PINS_PER_BANK;
    end
    return sh[REG_W-1:0] & REG_MASK;
  endfunction

endpackage

// ===== sv/gpr_in_stage.sv =====
// Input register stage of the GPIO port registers: captures one bus access per transfer.
// Depends on gpr_pkg.
module gpr_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gpr_pkg::gpr_access_t in_acc,
  output logic                s_valid,
  input  logic                s_ready,
  output gpr_pkg::gpr_access_t s_acc
);

  logic                 s_valid_r;
  gpr_pkg::gpr_access_t s_acc_r;
  logic                 advance;

  // Hold the captured access while the next stage cannot take it.
  assign advance  = !s_valid_r || s_ready;
  assign in_stall = !advance;
  assign s_valid  = s_valid_r;
  assign s_acc    = s_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (advance) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s_acc_r <= in_acc;
    end
  end

endmodule

// ===== sv/gpr_regfile.sv =====
// Register file, pin state update and result register of the GPIO port registers.
// Depends on gpr_pkg.
module gpr_regfile (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             s_valid,
  output logic                             s_ready,
  input  gpr_pkg::gpr_access_t             s_acc,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gpr_pkg::REG_W-1:0]        out_read_data,
  output logic [gpr_pkg::NUM_PINS-1:0]     out_pin_levels,
  output logic [gpr_pkg::NUM_PINS-1:0]     out_pin_is_input
);

  logic [gpr_pkg::NUM_PINS-1:0] dir_r, dir_nxt;
  logic [gpr_pkg::NUM_PINS-1:0] inv_r, inv_nxt;
  logic [gpr_pkg::NUM_PINS-1:0] pin_r, pin_nxt;
  logic [gpr_pkg::NUM_PINS-1:0] pend_set_r, pend_set_nxt;
  logic [gpr_pkg::NUM_PINS-1:0] pend_clr_r, pend_clr_nxt;
  logic [7:0]                   irq_r, irq_nxt;
  logic [14:0]                  fsel_r, fsel_nxt;
  logic [gpr_pkg::REG_W-1:0]    bitrate_r, bitrate_nxt;
  logic [gpr_pkg::REG_W-1:0]    rd_nxt;
  logic [gpr_pkg::REG_W-1:0]    rd_r;
  logic                         out_valid_r;
  logic                         fire;

  assign s_ready = !(out_valid_r && out_stall);
  assign fire    = s_valid && s_ready;

  always_comb begin
    logic                         bank;
    logic [gpr_pkg::NUM_PINS-1:0] field;
    logic [gpr_pkg::NUM_PINS-1:0] req;
    logic [gpr_pkg::NUM_PINS-1:0] newdir;
    logic [gpr_pkg::NUM_PINS-1:0] to_out;
    bank         = s_acc.idx[0];
    field        = gpr_pkg::bank_up(gpr_pkg::REG_MASK, bank);
    req          = gpr_pkg::bank_up(s_acc.data & gpr_pkg::REG_MASK, bank);
    newdir       = (dir_r & ~field) | req;
    to_out       = dir_r & ~newdir;
    dir_nxt      = dir_r;
    inv_nxt      = inv_r;
    pin_nxt      = pin_r;
    pend_set_nxt = pend_set_r;
    pend_clr_nxt = pend_clr_r;
    irq_nxt      = irq_r;
    fsel_nxt     = fsel_r;
    bitrate_nxt  = bitrate_r;
    rd_nxt       = '0;
    if (s_acc.op == gpr_pkg::OP_READ) begin
      case (s_acc.idx)
        gpr_pkg::REG_DIR0, gpr_pkg::REG_DIR1: begin
          rd_nxt = gpr_pkg::bank_down(dir_r, bank);
        end
        gpr_pkg::REG_INV0, gpr_pkg::REG_INV1: begin
          rd_nxt = gpr_pkg::bank_down(inv_r, bank);
        end
        gpr_pkg::REG_SET0, gpr_pkg::REG_SET1, gpr_pkg::REG_CLR0, gpr_pkg::REG_CLR1: begin
          rd_nxt = gpr_pkg::bank_down(dir_r & (pin_r ^ inv_r), bank);
        end
        gpr_pkg::REG_IRQ:     rd_nxt = {{(gpr_pkg::REG_W-8){1'b0}}, irq_r};
        gpr_pkg::REG_FSEL:    rd_nxt = {{(gpr_pkg::REG_W-15){1'b0}}, fsel_r};
        gpr_pkg::REG_BITRATE: rd_nxt = bitrate_r;
        default:              rd_nxt = '0;
      endcase
    end else begin
      case (s_acc.idx)
        gpr_pkg::REG_DIR0, gpr_pkg::REG_DIR1: begin
          // Apply pending set first, then pending clear, on pins turning to output.
          pin_nxt = (pin_r | (to_out & pend_set_r)) & ~(to_out & pend_clr_r);
          dir_nxt = newdir;
        end
        gpr_pkg::REG_INV0, gpr_pkg::REG_INV1: begin
          inv_nxt = (inv_r & ~field) | req;
        end
        gpr_pkg::REG_SET0, gpr_pkg::REG_SET1: begin
          pend_set_nxt = pend_set_r | (req & dir_r);
          pin_nxt      = pin_r | (req & ~dir_r);
        end
        gpr_pkg::REG_CLR0, gpr_pkg::REG_CLR1: begin
          pend_clr_nxt = pend_clr_r | (req & dir_r);
          pin_nxt      = pin_r & ~(req & ~dir_r);
        end
        gpr_pkg::REG_IRQ:     irq_nxt     = s_acc.data[7:0] & gpr_pkg::IRQ_MASK;
        gpr_pkg::REG_FSEL:    fsel_nxt    = s_acc.data[14:0] & gpr_pkg::FSEL_MASK;
        gpr_pkg::REG_BITRATE: bitrate_nxt = s_acc.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= '1;
      inv_r       <= '0;
      pin_r       <= '0;
      pend_set_r  <= '0;
      pend_clr_r  <= '0;
      irq_r       <= '0;
      fsel_r      <= '0;
      bitrate_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        dir_r      <= dir_nxt;
        inv_r      <= inv_nxt;
        pin_r      <= pin_nxt;
        pend_set_r <= pend_set_nxt;
        pend_clr_r <= pend_clr_nxt;
        irq_r      <= irq_nxt;
        fsel_r     <= fsel_nxt;
        bitrate_r  <= bitrate_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r <= rd_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = rd_r;
  assign out_pin_levels   = pin_r;
  assign out_pin_is_input = dir_r;

  // A read access leaves direction and pin state alone.
  a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s_acc.op == gpr_pkg::OP_READ |=> $stable(dir_r) && $stable(pin_r))
    else $error("read access changed pin state");

  // A write access returns zero read data.
  a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s_acc.op == gpr_pkg::OP_WRITE |=> rd_r == '0)
    else $error("write access returned nonzero read data");

  // Pending marks only accumulate.
  a_pending_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((pend_set_r & $past(pend_set_r)) == $past(pend_set_r))
          && ((pend_clr_r & $past(pend_clr_r)) == $past(pend_clr_r)))
    else $error("pending mark was lost");

  // Output pins record no pending marks from this access.
  a_pending_inputs_only: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> ((pend_set_r ^ $past(pend_set_r)) & ~$past(dir_r)) == '0)
    else $error("pending set recorded on an output pin");

endmodule

// ===== sv/gpio_port_registers_core.sv =====
// Top level of the GPIO port registers: input register stage feeding the register file.
// Depends on gpr_pkg, gpr_in_stage and gpr_regfile.
//
// Register bank for a 32-pin GPIO controller in two banks of gpr_pkg::PINS_PER_BANK pins.
// Each input transfer is one bus access (read or write of registers dir0/1, inv0/1,
// set0/1, clr0/1, irq, fsel, bitrate) and yields exactly one result transfer carrying the
// read data (zero on writes), the pin levels and the pin directions after the access.
// A direction bit of 1 marks an input. Set and clear writes drive output pins at once and
// record a pending mark on input pins; the marks are applied (set, then clear) when a pin
// turns to output and are never removed. Set/clear reads return input levels XOR invert.
// Rate: one transfer per clock cycle while out_stall is low; each access passes through
// the input register and then the register-update logic into the result register. The
// result register holds while out_stall is high, and in_stall rises only once both the
// result register and the input register are occupied.
module gpio_port_registers_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [3:0]                    in_register_index,
  input  logic [gpr_pkg::REG_W-1:0]     in_write_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gpr_pkg::REG_W-1:0]     out_read_data,
  output logic [gpr_pkg::NUM_PINS-1:0]  out_pin_levels,
  output logic [gpr_pkg::NUM_PINS-1:0]  out_pin_is_input
);

  gpr_pkg::gpr_access_t in_acc;
  gpr_pkg::gpr_access_t s_acc;
  logic                 s_valid;
  logic                 s_ready;

  // Bundle the access fields for the input register.
  assign in_acc.op   = gpr_pkg::gpr_op_e'(in_operation);
  assign in_acc.idx  = in_register_index;
  assign in_acc.data = in_write_data;

  gpr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_acc   (in_acc),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_acc    (s_acc)
  );

  // Update register state and capture the result in one pass.
  gpr_regfile u_regfile (
    .clk              (clk),
    .rst_n            (rst_n),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_acc            (s_acc),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_pin_levels   (out_pin_levels),
    .out_pin_is_input (out_pin_is_input)
  );

  // Input side stalls only when the result is waiting and blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // An access held in the input register moves on as soon as the output drains.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid && !out_stall |=> out_valid)
    else $error("held access did not reach the result register");

endmodule
